>>> design/ims_pkg.sv
package ims_pkg;

	localparam int DEF_BUFFER_DEPTH = 32;
	localparam int LEN_W = 6;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;
	localparam logic [1:0] MODE_STATUS = 2'd3;

	// master status codes of the bus engine
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RSTART      = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_TX_ACK = 8'h28;
	localparam logic [7:0] ST_DATA_TX_NAK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST    = 8'h38;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
	localparam logic [7:0] ST_DATA_RX_ACK = 8'h50;
	localparam logic [7:0] ST_DATA_RX_NAK = 8'h58;

	typedef struct packed {
		logic [1:0]       mode;
		logic [4:0]       buffer_index;
		logic [7:0]       load_byte;
		logic [7:0]       target_address;
		logic [LEN_W-1:0] transfer_length;
		logic [7:0]       bus_status;
		logic [7:0]       received_byte;
	} item_t;

	typedef struct packed {
		logic txv;
		logic tx_mem;
		logic tx_addr;
		logic ssta;
		logic csta;
		logic sto;
		logic sack;
		logic cack;
		logic ovf;
		logic rb_mem;
		logic load_txn;
		logic set_end;
		logic set_ok;
	} act_t;

	typedef struct packed {
		logic       txv;
		logic       tx_mem;
		logic [7:0] tx_byte;
		logic       ssta;
		logic       csta;
		logic       sto;
		logic       sack;
		logic       cack;
		logic       done;
		logic       ok;
		logic       rb_mem;
		logic       ovf;
	} res_t;

endpackage

>>> design/ims_in_if.sv
interface ims_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [4:0] buffer_index;
	logic [7:0] load_byte;
	logic [7:0] target_address;
	logic [5:0] transfer_length;
	logic [7:0] bus_status;
	logic [7:0] received_byte;

	modport source (
		output valid, mode, buffer_index, load_byte, target_address, transfer_length,
			bus_status, received_byte,
		input ready
	);
	modport sink (
		input valid, mode, buffer_index, load_byte, target_address, transfer_length,
			bus_status, received_byte,
		output ready
	);
endinterface

>>> design/ims_out_if.sv
interface ims_out_if;
	logic       valid;
	logic       ready;
	logic       transmit_valid;
	logic [7:0] transmit_byte;
	logic       set_start;
	logic       clear_start;
	logic       set_stop;
	logic       set_ack;
	logic       clear_ack;
	logic       done_res;
	logic       success;
	logic [7:0] readback_byte;
	logic       overflow;

	modport source (
		output valid, transmit_valid, transmit_byte, set_start, clear_start, set_stop,
			set_ack, clear_ack, done_res, success, readback_byte, overflow,
		input ready
	);
	modport sink (
		input valid, transmit_valid, transmit_byte, set_start, clear_start, set_stop,
			set_ack, clear_ack, done_res, success, readback_byte, overflow,
		output ready
	);
endinterface

>>> design/ims_buffer.sv
module ims_buffer import ims_pkg::*; #(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [BUFFER_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> design/ims_decode.sv
module ims_decode import ims_pkg::*; #(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
	parameter int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
	parameter int IW = $clog2(BUFFER_DEPTH + 1)
) (
	input  item_t            itm,
	input  logic [IW-1:0]    idx,
	input  logic [LEN_W-1:0] len,
	output act_t             act,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [7:0]       mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	output logic             idx_we,
	output logic [IW-1:0]    idx_nxt
);
	localparam int CW = (IW > LEN_W) ? IW : LEN_W;

	logic          bidx_ok;
	logic          idx_ok;
	logic [IW-1:0] idx_inc;
	logic [CW-1:0] idx_c;
	logic [CW-1:0] inc_c;
	logic [CW-1:0] len_c;

	assign bidx_ok = 32'(itm.buffer_index) < 32'(BUFFER_DEPTH);
	assign idx_ok  = 32'(idx) < 32'(BUFFER_DEPTH);
	assign idx_inc = idx + IW'(1);
	assign idx_c   = CW'(idx);
	assign inc_c   = CW'(idx_inc);
	assign len_c   = CW'(len);

	always_comb begin
		act       = '0;
		mem_we    = 1'b0;
		mem_waddr = AW'(itm.buffer_index);
		mem_wdata = itm.load_byte;
		mem_re    = 1'b0;
		mem_raddr = AW'(itm.buffer_index);
		idx_we    = 1'b0;
		idx_nxt   = idx_inc;
		case (itm.mode)
			MODE_LOAD: begin
				if (bidx_ok) mem_we = 1'b1;
				else act.ovf = 1'b1;
			end
			MODE_READ: begin
				if (bidx_ok) begin
					mem_re     = 1'b1;
					act.rb_mem = 1'b1;
				end else begin
					act.ovf = 1'b1;
				end
			end
			MODE_START: begin
				act.load_txn = 1'b1;
				act.ssta     = 1'b1;
			end
			MODE_STATUS: begin
				case (itm.bus_status)
					ST_START: begin
						act.txv     = 1'b1;
						act.tx_addr = 1'b1;
						act.csta    = 1'b1;
						if (idx_c >= len_c) begin
							act.sto     = 1'b1;
							act.set_end = 1'b1;
						end
					end
					ST_RSTART: begin
						idx_we      = 1'b1;
						idx_nxt     = '0;
						act.txv     = 1'b1;
						act.tx_addr = 1'b1;
						act.csta    = 1'b1;
					end
					ST_SLA_W_ACK, ST_DATA_TX_ACK: begin
						if (itm.bus_status == ST_DATA_TX_ACK && idx_c == len_c) begin
							act.sto     = 1'b1;
							act.set_end = 1'b1;
							act.set_ok  = 1'b1;
						end else if (idx_ok) begin
							act.txv    = 1'b1;
							act.tx_mem = 1'b1;
							mem_re     = 1'b1;
							mem_raddr  = AW'(idx);
							idx_we     = 1'b1;
						end else begin
							act.ovf = 1'b1;
						end
					end
					ST_ARB_LOST: act.ssta = 1'b1;
					ST_SLA_R_ACK: act.sack = 1'b1;
					ST_DATA_RX_ACK: begin
						if (idx_ok) begin
							mem_we    = 1'b1;
							mem_waddr = AW'(idx);
							mem_wdata = itm.received_byte;
							idx_we    = 1'b1;
						end else begin
							act.ovf = 1'b1;
						end
						// nack the byte that will fill the transfer
						if ((idx_ok ? inc_c : idx_c) == len_c) act.cack = 1'b1;
						else act.sack = 1'b1;
					end
					ST_DATA_RX_NAK: begin
						act.sto     = 1'b1;
						act.set_end = 1'b1;
						act.set_ok  = 1'b1;
					end
					default: begin
						act.sto     = 1'b1;
						act.set_end = 1'b1;
					end
				endcase
			end
			default: ;
		endcase
	end
endmodule

>>> design/i2c_master_status_sequencer.sv
// sequencer of an i2c master, one decision per item
// item channel: load or read back a buffer byte, start a transaction with an
// address byte and a length, or report one bus status code with the byte received
// result channel: one result per item with the control actions (start set or
// clear, stop, ack or nack), a byte to load into the data register, the done and
// success flags, a read-back byte and the overflow mark
// an accepted item is registered in the input stage, where it is decoded and the
// buffer memory is written or read; when the output register can advance, the
// result is registered there and shown from that register
// throughput is one item per cycle while the receiver does not stall; the read of
// the buffer memory and the index update both finish within the input stage
// when the receiver stalls the result holds in the output register and one more
// item is still taken into the input stage; beyond that the item channel stalls
// reset clears the pipeline valids, the index, the length, the address byte and
// both flags; the buffer contents stay undefined until written
module i2c_master_status_sequencer import ims_pkg::*; #(
	parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH
) (
	input logic       clk,
	input logic       arst_n,
	ims_in_if.sink    item,
	ims_out_if.source result
);
	localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int IW = $clog2(BUFFER_DEPTH + 1);

	item_t            item_s1;
	logic             valid_s1;
	res_t             res_s2;
	logic             valid_s2;
	res_t             res_d;

	logic [IW-1:0]    idx_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       addr_q;
	logic             ended_q;
	logic             ok_q;

	act_t             act;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [7:0]       mem_rdata;
	logic             idx_we;
	logic [IW-1:0]    idx_nxt;

	logic             adv_s2;
	logic             fire_s1;
	logic             take;

	assign adv_s2     = !valid_s2 || result.ready;
	assign fire_s1    = valid_s1 && adv_s2;
	assign item.ready = !valid_s1 || adv_s2;
	assign take       = item.valid && item.ready;

	ims_decode #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.AW(AW),
		.IW(IW)
	) u_decode (
		.itm(item_s1),
		.idx(idx_q),
		.len(len_q),
		.act(act),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.idx_we(idx_we),
		.idx_nxt(idx_nxt)
	);

	ims_buffer #(
		.BUFFER_DEPTH(BUFFER_DEPTH),
		.AW(AW)
	) u_buffer (
		.clk(clk),
		.we(fire_s1 && mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(fire_s1 && mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		res_d.txv     = act.txv;
		res_d.tx_mem  = act.tx_mem;
		res_d.tx_byte = act.tx_addr ? addr_q : 8'h00;
		res_d.ssta    = act.ssta;
		res_d.csta    = act.csta;
		res_d.sto     = act.sto;
		res_d.sack    = act.sack;
		res_d.cack    = act.cack;
		res_d.done    = !act.load_txn && (ended_q || act.set_end);
		res_d.ok      = !act.load_txn && (ok_q || act.set_ok);
		res_d.rb_mem  = act.rb_mem;
		res_d.ovf     = act.ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (fire_s1) valid_s1 <= 1'b0;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) item_s1 <= item_t'({item.mode, item.buffer_index, item.load_byte,
			item.target_address, item.transfer_length, item.bus_status,
			item.received_byte});
		if (fire_s1) res_s2 <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			len_q   <= '0;
			addr_q  <= '0;
			ended_q <= 1'b0;
			ok_q    <= 1'b0;
		end else if (fire_s1) begin
			if (act.load_txn) begin
				idx_q   <= '0;
				len_q   <= item_s1.transfer_length;
				addr_q  <= item_s1.target_address;
				ended_q <= 1'b0;
				ok_q    <= 1'b0;
			end else begin
				if (idx_we) idx_q <= idx_nxt;
				if (act.set_end) ended_q <= 1'b1;
				if (act.set_ok) ok_q <= 1'b1;
			end
		end
	end

	assign result.valid          = valid_s2;
	assign result.transmit_valid = res_s2.txv;
	assign result.transmit_byte  = res_s2.tx_mem ? mem_rdata : res_s2.tx_byte;
	assign result.set_start      = res_s2.ssta;
	assign result.clear_start    = res_s2.csta;
	assign result.set_stop       = res_s2.sto;
	assign result.set_ack        = res_s2.sack;
	assign result.clear_ack      = res_s2.cack;
	assign result.done_res       = res_s2.done;
	assign result.success        = res_s2.ok;
	assign result.readback_byte  = res_s2.rb_mem ? mem_rdata : 8'h00;
	assign result.overflow       = res_s2.ovf;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) <= 32'(BUFFER_DEPTH))
		else $error("byte index beyond buffer depth");

	a_ok_implies_end: assert property (@(posedge clk) disable iff (!arst_n)
		ok_q |-> ended_q)
		else $error("success flag without done flag");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.mode == MODE_START |=> idx_q == '0 && !ended_q && !ok_q)
		else $error("start item did not clear transaction state");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready && valid_s1 |-> !item.ready)
		else $error("item taken with both stages full");
endmodule
